@@ rtl/bmp_rgb888_to_rgb565_defines.svh @@
// ----------------------------------------------------------------------------
// BMP to RGB565 assertion macros
// Concurrent assertion wrappers that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BMP_RGB888_TO_RGB565_DEFINES_SVH
`define BMP_RGB888_TO_RGB565_DEFINES_SVH

`ifndef SYNTHESIS
`define BMP_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");
`define BMP_ASSERT_ANY(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define BMP_ASSERT(name, clk, rst_n, prop)
`define BMP_ASSERT_ANY(name, clk, prop)
`endif

`endif

@@ rtl/bmp565_pkg.sv @@
// ----------------------------------------------------------------------------
// BMP to RGB565 package
// Shared constants, status codes and record types of the BMP converter.
// ----------------------------------------------------------------------------
package bmp565_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);

    localparam int HDR_LEN   = 54;
    localparam int HDR_IDX_W = 6;

    localparam logic [7:0]  MAGIC_B  = 8'h42;
    localparam logic [7:0]  MAGIC_M  = 8'h4d;
    localparam logic [15:0] BPP_RGB  = 16'd24;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID     = 3'd1;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
    localparam logic [2:0] ST_TRUNCATED   = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd4;

    typedef struct packed {
        logic [2:0]       status;
        logic             offset_min;
        logic [31:0]      offset;
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
    } hdr_info_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic [9:0]  dest_x;
        logic [9:0]  dest_y;
        logic        is_pixel;
        logic [2:0]  status;
        logic        done_res;
    } res_t;

    function automatic res_t status_res(input logic [2:0] st);
        res_t r;
        r          = '0;
        r.status   = st;
        r.done_res = 1'b1;
        return r;
    endfunction

endpackage

@@ rtl/bmp565_hdr.sv @@
// ----------------------------------------------------------------------------
// BMP header capture
// Keeps the header fields as their bytes arrive and checks them.
// ----------------------------------------------------------------------------
module bmp565_hdr (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [bmp565_pkg::HDR_IDX_W-1:0]    wr_idx,
    input  logic [7:0]                          wr_byte,
    output bmp565_pkg::hdr_info_t               info
);

    localparam logic [5:0] MAG_POS = 6'd0;
    localparam logic [5:0] OFF_POS = 6'd10;
    localparam logic [5:0] WID_POS = 6'd18;
    localparam logic [5:0] HGT_POS = 6'd22;
    localparam logic [5:0] BPP_POS = 6'd28;
    localparam logic [5:0] CMP_POS = 6'd30;

    logic [7:0] magic_reg [2];
    logic [7:0] off_reg   [4];
    logic [7:0] wid_reg   [4];
    logic [7:0] hgt_reg   [4];
    logic [7:0] bpp_reg   [2];
    logic [7:0] cmp_reg   [4];

    logic [31:0] off_val;
    logic [31:0] wid_val;
    logic [31:0] hgt_val;
    logic [15:0] bpp_val;
    logic [31:0] cmp_val;
    logic        bad_dims;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            case (wr_idx) inside
                [MAG_POS:MAG_POS + 6'd1]: magic_reg[1'(wr_idx - MAG_POS)] <= wr_byte;
                [OFF_POS:OFF_POS + 6'd3]: off_reg[2'(wr_idx - OFF_POS)] <= wr_byte;
                [WID_POS:WID_POS + 6'd3]: wid_reg[2'(wr_idx - WID_POS)] <= wr_byte;
                [HGT_POS:HGT_POS + 6'd3]: hgt_reg[2'(wr_idx - HGT_POS)] <= wr_byte;
                [BPP_POS:BPP_POS + 6'd1]: bpp_reg[1'(wr_idx - BPP_POS)] <= wr_byte;
                [CMP_POS:CMP_POS + 6'd3]: cmp_reg[2'(wr_idx - CMP_POS)] <= wr_byte;
                default: ;
            endcase
        end
    end

    assign off_val = {off_reg[3], off_reg[2], off_reg[1], off_reg[0]};
    assign wid_val = {wid_reg[3], wid_reg[2], wid_reg[1], wid_reg[0]};
    assign hgt_val = {hgt_reg[3], hgt_reg[2], hgt_reg[1], hgt_reg[0]};
    assign bpp_val = {bpp_reg[1], bpp_reg[0]};
    assign cmp_val = {cmp_reg[3], cmp_reg[2], cmp_reg[1], cmp_reg[0]};

    assign bad_dims = (wid_val == 32'd0) || wid_val[31] || (hgt_val == 32'd0) || hgt_val[31];

    always_comb begin
        info            = '0;
        info.offset     = off_val;
        info.offset_min = (off_val == 32'(bmp565_pkg::HDR_LEN));
        info.width      = wid_val[bmp565_pkg::WID_W-1:0];
        info.height     = hgt_val[bmp565_pkg::HGT_W-1:0];
        if ((magic_reg[0] != bmp565_pkg::MAGIC_B) || (magic_reg[1] != bmp565_pkg::MAGIC_M)) begin
            info.status = bmp565_pkg::ST_INVALID;
        end else if (bad_dims || (bpp_val != bmp565_pkg::BPP_RGB) || (cmp_val != 32'd0) ||
                     (off_val < 32'(bmp565_pkg::HDR_LEN))) begin
            info.status = bmp565_pkg::ST_UNSUPPORTED;
        end else if ((wid_val > 32'(bmp565_pkg::MAX_WIDTH)) ||
                     (hgt_val > 32'(bmp565_pkg::MAX_HEIGHT))) begin
            info.status = bmp565_pkg::ST_TOO_LARGE;
        end else begin
            info.status = bmp565_pkg::ST_OK;
        end
    end

endmodule

@@ rtl/bmp565_parse.sv @@
// ----------------------------------------------------------------------------
// BMP stream parser
// Tracks the file position and turns each accepted byte into at most one result.
// ----------------------------------------------------------------------------
module bmp565_parse (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic [7:0]                          byte_value,
    input  logic                                last_byte,
    input  logic                                swap_bytes,
    input  bmp565_pkg::hdr_info_t               hdr,
    output logic                                hdr_wr_en,
    output logic [bmp565_pkg::HDR_IDX_W-1:0]    hdr_wr_idx,
    output logic                                res_valid,
    output bmp565_pkg::res_t                    res
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXEL  = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_DRAIN  = 3'd4;

    localparam int WID_W = bmp565_pkg::WID_W;
    localparam int HGT_W = bmp565_pkg::HGT_W;

    logic [2:0]       phase_reg, phase_next;
    logic [31:0]      count_reg, count_next;
    logic [WID_W-1:0] col_reg, col_next;
    logic [HGT_W-1:0] row_reg, row_next;
    logic [1:0]       tri_reg, tri_next;
    logic [1:0]       pad_reg, pad_next;
    logic [15:0]      held_reg, held_next;

    logic [WID_W-1:0] col_inc;
    logic [HGT_W-1:0] row_inc;
    logic             final_px;
    logic [15:0]      px_raw;
    logic [15:0]      px;

    assign hdr_wr_en  = accept && (phase_reg == PH_HEADER);
    assign hdr_wr_idx = count_reg[bmp565_pkg::HDR_IDX_W-1:0];

    assign col_inc  = col_reg + WID_W'(1);
    assign row_inc  = row_reg + HGT_W'(1);
    assign final_px = (col_inc == hdr.width) && (row_inc == hdr.height);
    assign px_raw   = {byte_value[7:3], held_reg[15:10], held_reg[7:3]};
    assign px       = swap_bytes ? {px_raw[7:0], px_raw[15:8]} : px_raw;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        tri_next   = tri_reg;
        pad_next   = pad_reg;
        held_next  = held_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (accept) begin
            case (phase_reg)
                PH_HEADER: begin
                    count_next = count_reg + 32'd1;
                    if (count_reg != 32'(bmp565_pkg::HDR_LEN - 1)) begin
                        if (last_byte) begin
                            res_valid = 1'b1;
                            res       = bmp565_pkg::status_res(bmp565_pkg::ST_INVALID);
                        end
                    end else if (hdr.status != bmp565_pkg::ST_OK) begin
                        res_valid  = 1'b1;
                        res        = bmp565_pkg::status_res(hdr.status);
                        phase_next = PH_DRAIN;
                    end else if (last_byte) begin
                        res_valid = 1'b1;
                        res       = bmp565_pkg::status_res(bmp565_pkg::ST_TRUNCATED);
                    end else begin
                        phase_next = hdr.offset_min ? PH_PIXEL : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    count_next = count_reg + 32'd1;
                    if (last_byte) begin
                        res_valid = 1'b1;
                        res       = bmp565_pkg::status_res(bmp565_pkg::ST_TRUNCATED);
                    end else if (count_next == hdr.offset) begin
                        phase_next = PH_PIXEL;
                    end
                end
                PH_PIXEL: begin
                    if (tri_reg == 2'd0) begin
                        held_next = {held_reg[15:8], byte_value};
                        tri_next  = 2'd1;
                    end else if (tri_reg == 2'd1) begin
                        held_next = {byte_value, held_reg[7:0]};
                        tri_next  = 2'd2;
                    end else begin
                        tri_next = 2'd0;
                    end
                    if (tri_reg != 2'd2) begin
                        if (last_byte) begin
                            res_valid = 1'b1;
                            res       = bmp565_pkg::status_res(bmp565_pkg::ST_TRUNCATED);
                        end
                    end else if (last_byte && !final_px) begin
                        res_valid = 1'b1;
                        res       = bmp565_pkg::status_res(bmp565_pkg::ST_TRUNCATED);
                    end else begin
                        res_valid    = 1'b1;
                        res.pixel    = px;
                        res.dest_x   = 10'(col_reg);
                        res.dest_y   = 10'(hdr.height - HGT_W'(1) - row_reg);
                        res.is_pixel = 1'b1;
                        res.status   = bmp565_pkg::ST_OK;
                        res.done_res = final_px;
                        col_next     = col_inc;
                        if (final_px) begin
                            phase_next = PH_DRAIN;
                        end else if (col_inc == hdr.width) begin
                            col_next = '0;
                            row_next = row_inc;
                            pad_next = hdr.width[1:0];
                            if (hdr.width[1:0] != 2'd0) begin
                                phase_next = PH_PAD;
                            end
                        end
                    end
                end
                PH_PAD: begin
                    if (last_byte) begin
                        res_valid = 1'b1;
                        res       = bmp565_pkg::status_res(bmp565_pkg::ST_TRUNCATED);
                    end else begin
                        pad_next = pad_reg - 2'd1;
                        if (pad_reg == 2'd1) begin
                            phase_next = PH_PIXEL;
                        end
                    end
                end
                default: ;
            endcase
            if (last_byte) begin
                phase_next = PH_HEADER;
                count_next = '0;
                col_next   = '0;
                row_next   = '0;
                tri_next   = '0;
                pad_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            tri_reg   <= '0;
            pad_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            tri_reg   <= tri_next;
            pad_reg   <= pad_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
    end

endmodule

@@ rtl/bmp565_out.sv @@
// ----------------------------------------------------------------------------
// BMP result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module bmp565_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  bmp565_pkg::res_t load_res,
    input  logic             m_ready,
    output logic             m_valid,
    output bmp565_pkg::res_t m_res,
    output logic             in_ready
);

    logic             valid_reg, valid_next;
    bmp565_pkg::res_t res_reg;

    assign in_ready   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= load_res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

@@ rtl/bmp_rgb888_to_rgb565.sv @@
// ----------------------------------------------------------------------------
// BMP 24 bpp to RGB565 converter
// Parses a byte stream of an uncompressed 24 bpp BMP file and emits RGB565
// pixels with their destination coordinates, or one status item on error.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle and gives at most one result item
// for each byte, in the cycle after the byte is accepted; a pixel item appears on
// the byte that completes its blue, green, red triple. The single result
// register sets the rate: a new byte is taken in every cycle in which that
// register is empty or being read. Images up to 1024 by 1024 pixels are
// accepted, and no start-up pass is needed after reset.
`include "bmp_rgb888_to_rgb565_defines.svh"

module bmp_rgb888_to_rgb565 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,   // swap_bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // byte_value
    input  logic        s_tlast,     // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // pixel, dest_x, dest_y, status, zero fill
    output logic        m_tuser,     // is_pixel
    output logic        m_tlast      // done_res
);

    logic                                swap_reg;
    logic                                accept;
    logic                                hdr_wr_en;
    logic [bmp565_pkg::HDR_IDX_W-1:0]    hdr_wr_idx;
    bmp565_pkg::hdr_info_t               hdr_info;
    logic                                res_valid;
    bmp565_pkg::res_t                    res;
    bmp565_pkg::res_t                    out_res;
    logic                                out_st_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_reg <= 1'b0;
        end else if (cfg_we) begin
            swap_reg <= cfg_wdata;
        end
    end

    assign accept = s_tvalid && s_tready;

    bmp565_hdr u_hdr (
        .aclk    (aclk),
        .wr_en   (hdr_wr_en),
        .wr_idx  (hdr_wr_idx),
        .wr_byte (s_tdata),
        .info    (hdr_info)
    );

    bmp565_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .byte_value (s_tdata),
        .last_byte  (s_tlast),
        .swap_bytes (swap_reg),
        .hdr        (hdr_info),
        .hdr_wr_en  (hdr_wr_en),
        .hdr_wr_idx (hdr_wr_idx),
        .res_valid  (res_valid),
        .res        (res)
    );

    bmp565_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .load_res (res),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_res    (out_res),
        .in_ready (s_tready)
    );

    assign m_tdata = {1'b0, out_res.status, out_res.dest_y, out_res.dest_x, out_res.pixel};
    assign m_tuser = out_res.is_pixel;
    assign m_tlast = out_res.done_res;

    assign out_st_ok = (out_res.status == bmp565_pkg::ST_OK);

    `BMP_ASSERT(a_status_ends_file, aclk, aresetn, (m_tvalid && !m_tuser) |-> m_tlast)
    `BMP_ASSERT(a_pixel_status_ok, aclk, aresetn, (m_tvalid && m_tuser) |-> out_st_ok)
    `BMP_ASSERT(a_ready_follows_out, aclk, aresetn, s_tready == (!m_tvalid || m_tready))
    `BMP_ASSERT_ANY(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)

endmodule
